### hdl/aik_pkg.sv
// Shared types, widths and constants of the arm inverse kinematics pipeline.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package aik_pkg;

  localparam int POS_W     = 16;
  localparam int LEN_W     = 15;
  localparam int DX_W      = 17;
  localparam int SQ_IN_W   = 64;
  localparam int SQ_N      = SQ_IN_W / 2;
  localparam int AT_W      = 32;
  localparam int CW        = 36;
  localparam int ANG_W     = 25;
  localparam int SUM_W     = 28;
  localparam int NORM_N    = 5;
  localparam int CORDIC_N  = 20;
  localparam int AT_N      = NORM_N + 1 + CORDIC_N;
  localparam int FRONT_N   = 4;
  localparam int MID_N     = 6;
  localparam int BACK_N    = 3;
  localparam int LAT       = FRONT_N + SQ_N + MID_N + SQ_N + 1 + AT_N + BACK_N;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_ARM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOREARM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_MAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SHLD_MIN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SHLD_MAX  = 3'd7;

  localparam logic [LEN_W-1:0]        RST_UPPER_ARM = 15'd8640;
  localparam logic [LEN_W-1:0]        RST_FOREARM   = 15'd9408;
  localparam logic signed [POS_W-1:0] RST_OFFSET_X  = 16'sd0;
  localparam logic signed [POS_W-1:0] RST_REACH     = 16'sd32767;
  localparam logic signed [POS_W-1:0] RST_BASE_MIN  = -16'sd5760;
  localparam logic signed [POS_W-1:0] RST_BASE_MAX  = 16'sd5760;
  localparam logic signed [POS_W-1:0] RST_SHLD_MIN  = -16'sd1280;
  localparam logic signed [POS_W-1:0] RST_SHLD_MAX  = 16'sd5440;

  localparam logic signed [POS_W-1:0] ELBOW_MIN = -16'sd640;
  localparam logic signed [POS_W-1:0] ELBOW_MAX = 16'sd6080;

  localparam int DEG90   = 90 * 65536;
  localparam int DEG180  = 180 * 65536;
  localparam int ANG_SAT = 23040;

  localparam int CORDIC_TAB [CORDIC_N] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  typedef struct packed {
    logic signed [DX_W-1:0]  dx;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic                    beyond;
    logic                    py_zero;
    logic [32:0]             c2;
  } sidea_t;

  typedef struct packed {
    logic signed [DX_W:0]    r;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic [DX_W-1:0]         dx_abs;
    logic                    py_zero;
  } car_t;

  typedef struct packed {
    logic        fail;
    logic [30:0] nm1;
    logic        neg1;
    logic [30:0] nm2;
    logic        neg2;
  } acs_t;

  typedef struct packed {
    car_t car;
    acs_t acs;
  } sideb_t;

  typedef struct packed {
    logic py_zero;
    logic fail;
  } sidec_t;

  // fine angle (1/65536 deg) to 1/64 deg, round half up, saturate
  function automatic logic signed [POS_W-1:0] to_out(input logic signed [SUM_W-1:0] f);
    logic signed [SUM_W-1:0] t;
    t = (f + SUM_W'(512)) >>> 10;
    if (t > SUM_W'(ANG_SAT)) t = SUM_W'(ANG_SAT);
    if (t < -SUM_W'(ANG_SAT)) t = -SUM_W'(ANG_SAT);
    return t[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

### hdl/aik_if.sv
// Valid/ready channel interfaces for position words in and joint angle words out.
// Depends on aik_pkg for field widths.
`default_nettype none
interface aik_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [aik_pkg::POS_W-1:0]  pos_x;
  logic signed [aik_pkg::POS_W-1:0]  pos_y;
  logic signed [aik_pkg::POS_W-1:0]  pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface aik_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [aik_pkg::POS_W-1:0]  base_angle;
  logic signed [aik_pkg::POS_W-1:0]  shoulder_angle;
  logic signed [aik_pkg::POS_W-1:0]  elbow_angle;
  logic                              status;
  modport source (output valid, base_angle, shoulder_angle, elbow_angle, status, input ready);
  modport sink   (input valid, base_angle, shoulder_angle, elbow_angle, status, output ready);
endinterface
`default_nettype wire

### hdl/aik_isqrt.sv
// Pipelined integer square root, one result bit per stage, floor result.
// Depends on aik_pkg for widths and stage count.
`default_nettype none
module aik_isqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [aik_pkg::SQ_IN_W-1:0] val_i,
  output logic [aik_pkg::SQ_N-1:0]    root_o
);
  localparam int N  = aik_pkg::SQ_N;
  localparam int RW = N + 2;

  logic [RW-1:0]              rem_q  [N];
  logic [RW-1:0]              rem_d  [N];
  logic [N-1:0]               root_q [N];
  logic [N-1:0]               root_d [N];
  logic [aik_pkg::SQ_IN_W-1:0] val_q [N];
  logic [aik_pkg::SQ_IN_W-1:0] val_d [N];

  always_comb begin
    logic [RW-1:0]               pr;
    logic [N-1:0]                pq;
    logic [aik_pkg::SQ_IN_W-1:0] pv;
    logic [RW+1:0]               tr;
    logic [RW+1:0]               tt;
    for (int s = 0; s < N; s++) begin
      if (s == 0) begin
        pr = '0;
        pq = '0;
        pv = val_i;
      end else begin
        pr = rem_q[s-1];
        pq = root_q[s-1];
        pv = val_q[s-1];
      end
      tr = {pr, pv[aik_pkg::SQ_IN_W-1 -: 2]};
      tt = {2'b00, pq, 2'b01};
      if (tr >= tt) begin
        rem_d[s]  = RW'(tr - tt);
        root_d[s] = {pq[N-2:0], 1'b1};
      end else begin
        rem_d[s]  = tr[RW-1:0];
        root_d[s] = {pq[N-2:0], 1'b0};
      end
      val_d[s] = {pv[aik_pkg::SQ_IN_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      val_q  <= val_d;
    end
  end

  assign root_o = root_q[N-1];
endmodule
`default_nettype wire

### hdl/aik_atan2.sv
// Pipelined atan2: leading-zero normalise, quadrant pre-rotation, CORDIC vectoring.
// Depends on aik_pkg for widths, stage counts and the arctangent table.
`default_nettype none
module aik_atan2 (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [aik_pkg::AT_W-1:0]  y_i,
  input  logic signed [aik_pkg::AT_W-1:0]  x_i,
  output logic signed [aik_pkg::ANG_W-1:0] ang_o
);
  localparam int AW = aik_pkg::AT_W;
  localparam int CW = aik_pkg::CW;
  localparam int GW = aik_pkg::ANG_W;
  localparam int NN = aik_pkg::NORM_N;
  localparam int CN = aik_pkg::CORDIC_N;

  logic signed [AW-1:0] nx_q [NN];
  logic signed [AW-1:0] ny_q [NN];
  logic signed [AW-1:0] nx_d [NN];
  logic signed [AW-1:0] ny_d [NN];
  logic signed [CW-1:0] px_q, py_q, px_d, py_d;
  logic signed [GW-1:0] pa_q, pa_d;
  logic signed [CW-1:0] cx_q [CN];
  logic signed [CW-1:0] cy_q [CN];
  logic signed [GW-1:0] ca_q [CN];
  logic signed [CW-1:0] cx_d [CN];
  logic signed [CW-1:0] cy_d [CN];
  logic signed [GW-1:0] ca_d [CN];

  always_comb begin
    logic signed [AW-1:0] xp, yp, xa, ya;
    logic [AW-2:0]        m;
    int unsigned          sh;
    for (int k = 0; k < NN; k++) begin
      sh = 1 << (NN - 1 - k);
      if (k == 0) begin
        xp = x_i;
        yp = y_i;
      end else begin
        xp = nx_q[k-1];
        yp = ny_q[k-1];
      end
      xa = xp[AW-1] ? -xp : xp;
      ya = yp[AW-1] ? -yp : yp;
      m  = xa[AW-2:0] | ya[AW-2:0];
      if ((m >> (AW - 1 - sh)) == '0) begin
        nx_d[k] = xp <<< sh;
        ny_d[k] = yp <<< sh;
      end else begin
        nx_d[k] = xp;
        ny_d[k] = yp;
      end
    end
  end

  always_comb begin
    logic signed [CW-1:0] xe, ye;
    xe = CW'(nx_q[NN-1]);
    ye = CW'(ny_q[NN-1]);
    if (xe[CW-1] && !ye[CW-1]) begin
      px_d = ye;
      py_d = -xe;
      pa_d = GW'(aik_pkg::DEG90);
    end else if (xe[CW-1]) begin
      px_d = -ye;
      py_d = xe;
      pa_d = -GW'(aik_pkg::DEG90);
    end else begin
      px_d = xe;
      py_d = ye;
      pa_d = '0;
    end
  end

  always_comb begin
    logic signed [CW-1:0] xp, yp;
    logic signed [GW-1:0] ap;
    for (int i = 0; i < CN; i++) begin
      if (i == 0) begin
        xp = px_q;
        yp = py_q;
        ap = pa_q;
      end else begin
        xp = cx_q[i-1];
        yp = cy_q[i-1];
        ap = ca_q[i-1];
      end
      if (!yp[CW-1]) begin
        cx_d[i] = xp + (yp >>> i);
        cy_d[i] = yp - (xp >>> i);
        ca_d[i] = ap + GW'(aik_pkg::CORDIC_TAB[i]);
      end else begin
        cx_d[i] = xp - (yp >>> i);
        cy_d[i] = yp + (xp >>> i);
        ca_d[i] = ap - GW'(aik_pkg::CORDIC_TAB[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q <= nx_d;
      ny_q <= ny_d;
      px_q <= px_d;
      py_q <= py_d;
      pa_q <= pa_d;
      cx_q <= cx_d;
      cy_q <= cy_d;
      ca_q <= ca_d;
    end
  end

  assign ang_o = ca_q[CN-1];
endmodule
`default_nettype wire

### hdl/arm_inverse_kinematics.sv
// Inverse kinematics of a two-link arm on a rotating base, fully pipelined.
// Depends on aik_pkg, aik_if, aik_isqrt and aik_atan2.
//
// Usage:
//  pos_i carries a tool position word (x, y, z in 1/64 mm); ang_o returns the
//  base, shoulder and elbow angles in 1/64 degree with a status bit (1 when
//  the point is out of reach, degenerate, or a joint is outside its limits).
//  The configuration port writes one register per cycle with cfg_we_i high;
//  write only while no word is in flight.
//  Throughput is one word per cycle unless ang_o stalls; the latency from
//  acceptance to ang_o.valid is set by two 32-stage square root pipelines
//  (distances, then acos sine terms) and a 26-stage normalise + CORDIC atan2.
//  The pipeline moves as one: while a result sits unaccepted on ang_o, every
//  stage holds and pos_i.ready is low; bubbles drain whenever the output
//  register is empty or being taken.
//  Reset clears all valid bits and loads the default arm geometry and limits.
`default_nettype none
module arm_inverse_kinematics (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [aik_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [aik_pkg::POS_W-1:0]        cfg_data_i,
  aik_in_if.sink                           pos_i,
  aik_out_if.source                        ang_o
);
  localparam int PW = aik_pkg::POS_W;
  localparam int DW = aik_pkg::DX_W;
  localparam int SN = aik_pkg::SQ_N;
  localparam int AN = aik_pkg::AT_N;
  localparam int GW = aik_pkg::ANG_W;
  localparam int SW = aik_pkg::SUM_W;
  localparam int AW = aik_pkg::AT_W;

  // configuration
  logic [aik_pkg::LEN_W-1:0] l1_q, l2_q;
  logic signed [PW-1:0] off_q, reach_q, bmin_q, bmax_q, smin_q, smax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q    <= aik_pkg::RST_UPPER_ARM;
      l2_q    <= aik_pkg::RST_FOREARM;
      off_q   <= aik_pkg::RST_OFFSET_X;
      reach_q <= aik_pkg::RST_REACH;
      bmin_q  <= aik_pkg::RST_BASE_MIN;
      bmax_q  <= aik_pkg::RST_BASE_MAX;
      smin_q  <= aik_pkg::RST_SHLD_MIN;
      smax_q  <= aik_pkg::RST_SHLD_MAX;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aik_pkg::CFG_UPPER_ARM: l1_q    <= cfg_data_i[aik_pkg::LEN_W-1:0];
        aik_pkg::CFG_FOREARM:   l2_q    <= cfg_data_i[aik_pkg::LEN_W-1:0];
        aik_pkg::CFG_OFFSET_X:  off_q   <= $signed(cfg_data_i);
        aik_pkg::CFG_REACH:     reach_q <= $signed(cfg_data_i);
        aik_pkg::CFG_BASE_MIN:  bmin_q  <= $signed(cfg_data_i);
        aik_pkg::CFG_BASE_MAX:  bmax_q  <= $signed(cfg_data_i);
        aik_pkg::CFG_SHLD_MIN:  smin_q  <= $signed(cfg_data_i);
        aik_pkg::CFG_SHLD_MAX:  smax_q  <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // flow control
  logic                    en;
  logic [aik_pkg::LAT-1:0] vld_q;

  assign en          = !vld_q[aik_pkg::LAT-1] || ang_o.ready;
  assign pos_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[aik_pkg::LAT-2:0], pos_i.valid};
    end
  end

  // front stages
  logic signed [PW-1:0] px0_q, py0_q, pz0_q;
  logic signed [DW-1:0] dx1_q;
  logic signed [PW-1:0] py1_q, pz1_q;
  logic                 beyond1_q, pyz1_q;
  logic [32:0]          dx2_q;
  logic [30:0]          py2_q, pz2_q;
  logic signed [DW-1:0] dx2c_q;
  logic signed [PW-1:0] py2c_q, pz2c_q;
  logic                 beyond2_q, pyz2_q;
  logic [32:0]          r2_q, c2_q;
  aik_pkg::sidea_t      sa3_q;
  logic signed [2*DW-1:0] dxsq;
  logic signed [2*PW-1:0] pysq, pzsq;

  assign dxsq = dx1_q * dx1_q;
  assign pysq = py1_q * py1_q;
  assign pzsq = pz1_q * pz1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px0_q     <= pos_i.pos_x;
      py0_q     <= pos_i.pos_y;
      pz0_q     <= pos_i.pos_z;
      dx1_q     <= DW'(px0_q) - DW'(off_q);
      py1_q     <= py0_q;
      pz1_q     <= pz0_q;
      beyond1_q <= px0_q >= reach_q;
      pyz1_q    <= py0_q == '0;
      dx2_q     <= dxsq[32:0];
      py2_q     <= pysq[30:0];
      pz2_q     <= pzsq[30:0];
      dx2c_q    <= dx1_q;
      py2c_q    <= py1_q;
      pz2c_q    <= pz1_q;
      beyond2_q <= beyond1_q;
      pyz2_q    <= pyz1_q;
      r2_q      <= dx2_q + 33'(py2_q);
      c2_q      <= dx2_q + 33'(py2_q) + 33'(pz2_q);
      sa3_q     <= '{dx: dx2c_q, py: py2c_q, pz: pz2c_q, beyond: beyond2_q,
                     py_zero: pyz2_q, c2: '0};
    end
  end

  // distances
  logic [SN-1:0] rsq_root, c_root;

  aik_isqrt u_sqrt_r (
    .clk_i (clk_i), .en_i (en), .val_i ({31'd0, r2_q}), .root_o (rsq_root)
  );
  aik_isqrt u_sqrt_c (
    .clk_i (clk_i), .en_i (en), .val_i ({31'd0, c2_q}), .root_o (c_root)
  );

  aik_pkg::sidea_t sa_q [SN];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q[0]    <= '{dx: sa3_q.dx, py: sa3_q.py, pz: sa3_q.pz, beyond: sa3_q.beyond,
                      py_zero: sa3_q.py_zero, c2: c2_q};
      for (int k = 1; k < SN; k++) sa_q[k] <= sa_q[k-1];
    end
  end

  // law of cosines terms
  aik_pkg::sidea_t       sa;
  logic signed [DW:0]    r4_d;
  logic [DW-1:0]         dxa4_d;
  aik_pkg::car_t         car4_q, car5_q, car6_q, car7_q, car8_q, car9_q;
  logic [32:0]           c24_q;
  logic [29:0]           l1sq4_q, l2sq4_q, l1l24_q;
  logic [31:0]           l1c4_q;
  logic                  fail4_q, fail5_q, fail6_q;
  logic signed [35:0]    n15_q, n25_q;
  logic [32:0]           d15_q, d16_q;
  logic [30:0]           d25_q, d26_q;
  logic [34:0]           an16_q, an26_q;
  logic                  neg16_q, neg26_q;
  aik_pkg::acs_t         acs7_q, acs8_q, acs9_q;
  logic [30:0]           dm17_q, dm27_q;
  logic [30:0]           a18_q, a28_q;
  logic [31:0]           b18_q, b28_q;
  logic [62:0]           pr19_q, pr29_q;
  aik_pkg::acs_t         acs7_d;
  logic [30:0]           dm17_d;
  logic [34:0]           ash1, dsh1;

  assign sa     = sa_q[SN-1];
  assign r4_d   = sa.py_zero ? (DW+1)'(sa.dx) : $signed({1'b0, rsq_root[DW-1:0]});
  assign dxa4_d = sa.dx[DW-1] ? DW'(-sa.dx) : DW'(sa.dx);

  always_comb begin
    acs7_d.fail = fail6_q || (d16_q == '0) || (an16_q > {2'b00, d16_q})
                  || (an26_q > {4'b0000, d26_q});
    if (d16_q[32]) begin
      ash1 = an16_q >> 2;
      dsh1 = {2'b00, d16_q} >> 2;
    end else if (d16_q[31]) begin
      ash1 = an16_q >> 1;
      dsh1 = {2'b00, d16_q} >> 1;
    end else begin
      ash1 = an16_q;
      dsh1 = {2'b00, d16_q};
    end
    acs7_d.nm1  = ash1[30:0];
    acs7_d.neg1 = neg16_q;
    acs7_d.nm2  = an26_q[30:0];
    acs7_d.neg2 = neg26_q;
    dm17_d      = dsh1[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      car4_q  <= '{r: r4_d, py: sa.py, pz: sa.pz, dx_abs: dxa4_d, py_zero: sa.py_zero};
      c24_q   <= sa.c2;
      l1sq4_q <= l1_q * l1_q;
      l2sq4_q <= l2_q * l2_q;
      l1l24_q <= l1_q * l2_q;
      l1c4_q  <= l1_q * c_root[DW-1:0];
      fail4_q <= sa.beyond || (r4_d == '0) || (l1_q == '0) || (l2_q == '0);

      car5_q  <= car4_q;
      n15_q   <= $signed({3'b000, c24_q}) + $signed({6'd0, l1sq4_q})
                 - $signed({6'd0, l2sq4_q});
      n25_q   <= $signed({6'd0, l1sq4_q}) + $signed({6'd0, l2sq4_q})
                 - $signed({3'b000, c24_q});
      d15_q   <= {l1c4_q, 1'b0};
      d25_q   <= {l1l24_q, 1'b0};
      fail5_q <= fail4_q;

      car6_q  <= car5_q;
      an16_q  <= n15_q[35] ? 35'(-n15_q) : 35'(n15_q);
      an26_q  <= n25_q[35] ? 35'(-n25_q) : 35'(n25_q);
      neg16_q <= n15_q[35];
      neg26_q <= n25_q[35];
      d16_q   <= d15_q;
      d26_q   <= d25_q;
      fail6_q <= fail5_q;

      car7_q  <= car6_q;
      acs7_q  <= acs7_d;
      dm17_q  <= dm17_d;
      dm27_q  <= d26_q;

      car8_q  <= car7_q;
      acs8_q  <= acs7_q;
      a18_q   <= dm17_q - acs7_q.nm1;
      b18_q   <= {1'b0, dm17_q} + {1'b0, acs7_q.nm1};
      a28_q   <= dm27_q - acs7_q.nm2;
      b28_q   <= {1'b0, dm27_q} + {1'b0, acs7_q.nm2};

      car9_q  <= car8_q;
      acs9_q  <= acs8_q;
      pr19_q  <= a18_q * b18_q;
      pr29_q  <= a28_q * b28_q;
    end
  end

  // acos sine terms
  logic [SN-1:0] sq1_root, sq2_root;

  aik_isqrt u_sqrt_b (
    .clk_i (clk_i), .en_i (en), .val_i ({1'b0, pr19_q}), .root_o (sq1_root)
  );
  aik_isqrt u_sqrt_g (
    .clk_i (clk_i), .en_i (en), .val_i ({1'b0, pr29_q}), .root_o (sq2_root)
  );

  aik_pkg::sideb_t sb_q [SN];
  aik_pkg::sideb_t sb;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= '{car: car9_q, acs: acs9_q};
      for (int k = 1; k < SN; k++) sb_q[k] <= sb_q[k-1];
    end
  end

  assign sb = sb_q[SN-1];

  // angle units
  logic signed [AW-1:0] ay_a_q, ax_a_q, ay_s_q, ax_s_q, ay_b_q, ax_b_q, ay_g_q, ax_g_q;
  aik_pkg::sidec_t      sc10_q;
  aik_pkg::sidec_t      sc_q [AN];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ay_a_q <= AW'(sb.car.pz);
      ax_a_q <= AW'(sb.car.r);
      ay_s_q <= AW'(sb.car.py);
      ax_s_q <= $signed(AW'(sb.car.dx_abs));
      ay_b_q <= $signed(sq1_root);
      ax_b_q <= sb.acs.neg1 ? -$signed({1'b0, sb.acs.nm1}) : $signed({1'b0, sb.acs.nm1});
      ay_g_q <= $signed(sq2_root);
      ax_g_q <= sb.acs.neg2 ? -$signed({1'b0, sb.acs.nm2}) : $signed({1'b0, sb.acs.nm2});
      sc10_q <= '{py_zero: sb.car.py_zero, fail: sb.acs.fail};
      sc_q[0] <= sc10_q;
      for (int k = 1; k < AN; k++) sc_q[k] <= sc_q[k-1];
    end
  end

  logic signed [GW-1:0] alpha, base, beta, gamma;

  aik_atan2 u_atan_alpha (
    .clk_i (clk_i), .en_i (en), .y_i (ay_a_q), .x_i (ax_a_q), .ang_o (alpha)
  );
  aik_atan2 u_atan_base (
    .clk_i (clk_i), .en_i (en), .y_i (ay_s_q), .x_i (ax_s_q), .ang_o (base)
  );
  aik_atan2 u_atan_beta (
    .clk_i (clk_i), .en_i (en), .y_i (ay_b_q), .x_i (ax_b_q), .ang_o (beta)
  );
  aik_atan2 u_atan_gamma (
    .clk_i (clk_i), .en_i (en), .y_i (ay_g_q), .x_i (ax_g_q), .ang_o (gamma)
  );

  // back end: joint sums, rounding, limits
  logic signed [SW-1:0] j1f_q, j2f_q, j3f_q;
  aik_pkg::sidec_t      sc11_q;
  logic signed [PW-1:0] j1_q, j2_q, j3_q;
  logic                 fail12_q;
  logic signed [PW-1:0] base_q, shld_q, elbow_q;
  logic                 status_q;
  logic                 lim_bad;

  assign lim_bad = (j1_q < bmin_q) || (j1_q > bmax_q) || (j2_q < smin_q) || (j2_q > smax_q)
                   || (j3_q < aik_pkg::ELBOW_MIN) || (j3_q > aik_pkg::ELBOW_MAX);

  always_ff @(posedge clk_i) begin
    if (en) begin
      j1f_q    <= SW'(base);
      j2f_q    <= SW'(aik_pkg::DEG90) - SW'(alpha) - SW'(beta);
      j3f_q    <= SW'(aik_pkg::DEG180) - SW'(alpha) - SW'(beta) - SW'(gamma);
      sc11_q   <= sc_q[AN-1];

      j1_q     <= sc11_q.py_zero ? '0 : aik_pkg::to_out(j1f_q);
      j2_q     <= aik_pkg::to_out(j2f_q);
      j3_q     <= aik_pkg::to_out(j3f_q);
      fail12_q <= sc11_q.fail;

      base_q   <= fail12_q ? '0 : j1_q;
      shld_q   <= fail12_q ? '0 : j2_q;
      elbow_q  <= fail12_q ? '0 : j3_q;
      status_q <= fail12_q || lim_bad;
    end
  end

  assign ang_o.valid          = vld_q[aik_pkg::LAT-1];
  assign ang_o.base_angle     = base_q;
  assign ang_o.shoulder_angle = shld_q;
  assign ang_o.elbow_angle    = elbow_q;
  assign ang_o.status         = status_q;
endmodule
`default_nettype wire
